// ===== src/lpd_pkg.sv =====
// ============================================================================
// lpd_pkg: shared types and constants of the lidar packet deframer
// Header bytes, angle constants and the sample store write record.
// ============================================================================
package lpd_pkg;

  // Frame header, in order of arrival.
  localparam logic [7:0] HDR_BYTE0 = 8'h55;
  localparam logic [7:0] HDR_BYTE1 = 8'hAA;
  localparam logic [7:0] HDR_BYTE2 = 8'h03;
  localparam logic [7:0] HDR_BYTE3 = 8'h08;
  localparam logic [1:0] HDR_LAST  = 2'd3;

  // Body layout: byte offsets within the 32-byte body.
  localparam logic [4:0] BODY_SPEED_LO = 5'd0;
  localparam logic [4:0] BODY_SPEED_HI = 5'd1;
  localparam logic [4:0] BODY_START_LO = 5'd2;
  localparam logic [4:0] BODY_START_HI = 5'd3;
  localparam logic [4:0] BODY_SAMP_LO  = 5'd4;
  localparam logic [4:0] BODY_SAMP_HI  = 5'd27;
  localparam logic [4:0] BODY_END_LO   = 5'd28;
  localparam logic [4:0] BODY_END_HI   = 5'd29;
  localparam logic [4:0] BODY_LAST     = 5'd31;

  // Position of a byte within one (distance, intensity) triple.
  localparam logic [1:0] TRIP_DIST_LO = 2'd0;
  localparam logic [1:0] TRIP_DIST_HI = 2'd1;
  localparam logic [1:0] TRIP_INTENS  = 2'd2;

  // Samples per packet.
  localparam int unsigned NUM_SAMPLES = 8;
  localparam int unsigned SAMP_AW     = $clog2(NUM_SAMPLES);
  localparam logic [SAMP_AW-1:0] SAMP_LAST = SAMP_AW'(NUM_SAMPLES - 1);

  // Sample store entry: distance word above intensity byte.
  localparam int unsigned SAMP_DW = 24;

  // Angle arithmetic in 1/64 degree.
  localparam logic signed [16:0] ANGLE_BIAS = 17'sd40960;
  localparam logic signed [16:0] FULL_TURN  = 17'sd23040;

  // Width of the interpolated angle (1/512 degree) and of the result.
  localparam int unsigned ACC_W = 22;
  localparam int unsigned Q16_W = 22;

  // Degrees*512 to Q16 radians: factor 37480660 / 2^24, split in halves.
  localparam logic [25:0] RAD_FACTOR = 26'd37480660;
  localparam int unsigned FACT_SPLIT = 13;
  localparam logic [12:0] FACT_LO    = RAD_FACTOR[12:0];
  localparam logic [12:0] FACT_HI    = RAD_FACTOR[25:13];
  localparam int unsigned RAD_SHIFT  = 24;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OFFSET       = 2'd0;
  localparam logic [1:0] CFG_INVERT_ANGLE = 2'd1;
  localparam logic [1:0] CFG_RING_LENGTH  = 2'd2;

  // One write into the sample store.
  typedef struct packed {
    logic               en;
    logic [SAMP_AW-1:0] addr;
    logic [SAMP_DW-1:0] data;
  } samp_wr_t;

  // Expected header byte at a given header position.
  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] val;
    unique case (pos)
      2'd0:    val = HDR_BYTE0;
      2'd1:    val = HDR_BYTE1;
      2'd2:    val = HDR_BYTE2;
      default: val = HDR_BYTE3;
    endcase
    return val;
  endfunction

endpackage

// ===== src/lpd_sample_ram.sv =====
// ============================================================================
// lpd_sample_ram: sample store of one packet
// Eight entries of distance and intensity, one write and one registered read.
// ============================================================================
module lpd_sample_ram (
  input  logic                               clk,
  input  lpd_pkg::samp_wr_t                  wr,
  input  logic                               rd_en,
  input  logic [lpd_pkg::SAMP_AW-1:0]        rd_addr,
  output logic [lpd_pkg::SAMP_DW-1:0]        rd_data
);

  logic [lpd_pkg::SAMP_DW-1:0] mem [lpd_pkg::NUM_SAMPLES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/lpd_byte_parser.sv =====
// ============================================================================
// lpd_byte_parser: header hunt and body capture
// Finds the 55 AA 03 08 header, then takes the 32 body bytes apart.
// ============================================================================
module lpd_byte_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_take,
  input  logic [7:0]        byte_data,
  output logic [15:0]       speed_word,
  output logic [15:0]       start_word,
  output logic [15:0]       end_word,
  output lpd_pkg::samp_wr_t samp_wr,
  output logic              pkt_done
);

  logic [1:0]                        hdr_pos;
  logic                              in_body;
  logic [4:0]                        body_count;
  logic [1:0]                        trip_pos;
  logic [lpd_pkg::SAMP_AW-1:0]       samp_idx;
  logic [15:0]                       dist_word;
  logic                              in_samples;

  assign in_samples = (body_count >= lpd_pkg::BODY_SAMP_LO) &&
                      (body_count <= lpd_pkg::BODY_SAMP_HI);

  // A sample entry is complete on its intensity byte.
  always_comb begin
    samp_wr.en   = byte_take && in_body && in_samples &&
                   (trip_pos == lpd_pkg::TRIP_INTENS);
    samp_wr.addr = samp_idx;
    samp_wr.data = {dist_word, byte_data};
  end

  assign pkt_done = byte_take && in_body && (body_count == lpd_pkg::BODY_LAST);

  // Header search and body byte counting.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos    <= 2'd0;
      in_body    <= 1'b0;
      body_count <= 5'd0;
      trip_pos   <= lpd_pkg::TRIP_DIST_LO;
      samp_idx   <= '0;
    end else if (byte_take) begin
      if (!in_body) begin
        if (byte_data == lpd_pkg::hdr_byte(hdr_pos)) begin
          if (hdr_pos == lpd_pkg::HDR_LAST) begin
            hdr_pos    <= 2'd0;
            in_body    <= 1'b1;
            body_count <= 5'd0;
            trip_pos   <= lpd_pkg::TRIP_DIST_LO;
            samp_idx   <= '0;
          end else begin
            hdr_pos <= hdr_pos + 2'd1;
          end
        end else begin
          // The mismatching byte is dropped, not retried as a first byte.
          hdr_pos <= 2'd0;
        end
      end else begin
        if (body_count == lpd_pkg::BODY_LAST) begin
          in_body    <= 1'b0;
          body_count <= 5'd0;
        end else begin
          body_count <= body_count + 5'd1;
        end
        if (in_samples) begin
          if (trip_pos == lpd_pkg::TRIP_INTENS) begin
            trip_pos <= lpd_pkg::TRIP_DIST_LO;
            samp_idx <= samp_idx + lpd_pkg::SAMP_AW'(1);
          end else begin
            trip_pos <= trip_pos + 2'd1;
          end
        end
      end
    end
  end

  // Little-endian word capture from the body.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_word <= 16'd0;
      start_word <= 16'd0;
      end_word   <= 16'd0;
    end else if (byte_take && in_body) begin
      case (body_count)
        lpd_pkg::BODY_SPEED_LO: speed_word[7:0]  <= byte_data;
        lpd_pkg::BODY_SPEED_HI: speed_word[15:8] <= byte_data;
        lpd_pkg::BODY_START_LO: start_word[7:0]  <= byte_data;
        lpd_pkg::BODY_START_HI: start_word[15:8] <= byte_data;
        lpd_pkg::BODY_END_LO:   end_word[7:0]    <= byte_data;
        lpd_pkg::BODY_END_HI:   end_word[15:8]   <= byte_data;
        default: ;
      endcase
    end
  end

  // Distance bytes wait here until the intensity byte completes the entry.
  always_ff @(posedge clk) begin
    if (byte_take && in_body && in_samples) begin
      if (trip_pos == lpd_pkg::TRIP_DIST_LO) begin
        dist_word[7:0] <= byte_data;
      end else if (trip_pos == lpd_pkg::TRIP_DIST_HI) begin
        dist_word[15:8] <= byte_data;
      end
    end
  end

endmodule

// ===== src/lpd_rad_conv.sv =====
// ============================================================================
// lpd_rad_conv: angle scaling to Q16 radians
// Registered split multiply, then rounding half away from zero and clamp.
// ============================================================================
module lpd_rad_conv (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [lpd_pkg::ACC_W-1:0]    angle,
  output logic signed [lpd_pkg::Q16_W-1:0]    angle_q16
);

  localparam int unsigned MAG_W  = lpd_pkg::ACC_W;
  localparam int unsigned PROD_W = MAG_W + 13;
  localparam int unsigned SUM_W  = PROD_W + lpd_pkg::FACT_SPLIT + 1;
  localparam int unsigned QW     = SUM_W - lpd_pkg::RAD_SHIFT;
  localparam logic [QW-1:0] Q_LIMIT = QW'(1) << (lpd_pkg::Q16_W - 1);

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod_lo;
  logic [PROD_W-1:0] prod_hi;
  logic              neg;
  logic [SUM_W-1:0]  prod_sum;
  logic [QW-1:0]     q;
  logic [QW-1:0]     q_neg;

  assign mag = angle[MAG_W-1] ? MAG_W'(-angle) : MAG_W'(angle);

  // Two narrow partial products of the magnitude.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_lo <= PROD_W'(mag) * PROD_W'(lpd_pkg::FACT_LO);
      prod_hi <= PROD_W'(mag) * PROD_W'(lpd_pkg::FACT_HI);
      neg     <= angle[MAG_W-1];
    end
  end

  // Combine, round and apply the sign with saturation.
  always_comb begin
    prod_sum = (SUM_W'(prod_hi) << lpd_pkg::FACT_SPLIT) + SUM_W'(prod_lo) +
               (SUM_W'(1) << (lpd_pkg::RAD_SHIFT - 1));
    q        = prod_sum[SUM_W-1:lpd_pkg::RAD_SHIFT];
    q_neg    = (q > Q_LIMIT) ? Q_LIMIT : q;
    if (neg) begin
      angle_q16 = lpd_pkg::Q16_W'(-q_neg);
    end else if (q >= Q_LIMIT) begin
      angle_q16 = lpd_pkg::Q16_W'(Q_LIMIT - QW'(1));
    end else begin
      angle_q16 = lpd_pkg::Q16_W'(q);
    end
  end

endmodule

// ===== src/lidar_packet_deframer.sv =====
// ============================================================================
// lidar_packet_deframer: lidar serial packet deframer, top level
// Turns received lidar bytes into eight angle-tagged samples per packet.
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   transaction. in_ready is high while the block hunts for a header or
//   collects a body, so bytes are taken one per cycle.
//   After the last body byte of a packet in_ready drops for the emission of
//   the packet: setup in ST_PREP and ST_INIT, then for each sample a store
//   read, a multiply and a rounded output (ST_READ, ST_MUL, ST_OUT). The
//   sample store read and the split multiply are both registered.
//   Output channel (out_valid/out_ready) carries one sample per transaction,
//   the eighth with last_of_packet set. The output register lets the next
//   sample be prepared while one waits; a stalled receiver holds the
//   sequencer on the next sample and, after the eighth, input resumes.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready and is meant to be written while no packet is being emitted.
//   Reset (rst, synchronous) clears the framing state, the ring index, the
//   revolution flag and the registers to offset 0, no inversion, ring
//   length 1024. The sample store holds no reset value and needs no pass.
// ============================================================================
module lidar_packet_deframer #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [21:0] angle_rad_q16,
  output logic [15:0]        distance_raw,
  output logic [7:0]         intensity_raw,
  output logic [9:0]         ring_slot,
  output logic [15:0]        rpm_q6,
  output logic               revolution_seen,
  output logic               last_of_packet,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > 11) ? IDX_W + 1 : 11;
  localparam int unsigned ACC_W = lpd_pkg::ACC_W;

  typedef enum logic [5:0] {
    ST_RECV = 6'b000001,
    ST_PREP = 6'b000010,
    ST_INIT = 6'b000100,
    ST_READ = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_OUT  = 6'b100000
  } seq_state_t;

  seq_state_t state;
  seq_state_t state_next;

  logic signed [15:0]           offset_deg64;
  logic                         invert_angle;
  logic [10:0]                  ring_length;

  logic                         byte_take;
  logic [15:0]                  speed_word;
  logic [15:0]                  start_word;
  logic [15:0]                  end_word;
  lpd_pkg::samp_wr_t            samp_wr;
  logic                         pkt_done;

  logic                         rd_en;
  logic [lpd_pkg::SAMP_AW-1:0]  samp_idx;
  logic [lpd_pkg::SAMP_DW-1:0]  rd_data;

  logic signed [16:0]           s_ang;
  logic signed [16:0]           e_ang;
  logic signed [16:0]           e_wrap;
  logic signed [16:0]           previous_start;
  logic signed [17:0]           start_sum;
  logic signed [17:0]           span;
  logic signed [ACC_W-1:0]      base8;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      step;
  logic                         revolution_flag;

  logic [IDX_W-1:0]             write_index;
  logic [CMP_W-1:0]             ring_len_eff;
  logic [CMP_W-1:0]             index_inc;
  logic                         out_free;
  logic signed [21:0]           q16;

  assign in_ready  = (state == ST_RECV);
  assign byte_take = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_deg64 <= 16'sd0;
      invert_angle <= 1'b0;
      ring_length  <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpd_pkg::CFG_OFFSET:       offset_deg64 <= $signed(cfg_data);
        lpd_pkg::CFG_INVERT_ANGLE: invert_angle <= cfg_data[0];
        lpd_pkg::CFG_RING_LENGTH:  ring_length  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  lpd_byte_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_take  (byte_take),
    .byte_data  (rx_byte),
    .speed_word (speed_word),
    .start_word (start_word),
    .end_word   (end_word),
    .samp_wr    (samp_wr),
    .pkt_done   (pkt_done)
  );

  lpd_sample_ram u_ram (
    .clk     (clk),
    .wr      (samp_wr),
    .rd_en   (rd_en),
    .rd_addr (samp_idx),
    .rd_data (rd_data)
  );

  lpd_rad_conv u_rad (
    .clk       (clk),
    .load      (state == ST_MUL),
    .angle     (acc),
    .angle_q16 (q16)
  );

  assign rd_en = (state == ST_READ);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: if (pkt_done) state_next = ST_PREP;
      ST_PREP: state_next = ST_INIT;
      ST_INIT: state_next = ST_READ;
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = (samp_idx == lpd_pkg::SAMP_LAST) ? ST_RECV : ST_READ;
        end
      end
      default: state_next = ST_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // Packet angles relative to the bias, with end wrap.
  always_comb begin
    s_ang  = $signed({1'b0, start_word}) - lpd_pkg::ANGLE_BIAS;
    e_ang  = $signed({1'b0, end_word}) - lpd_pkg::ANGLE_BIAS;
    e_wrap = (e_ang < s_ang) ? e_ang + lpd_pkg::FULL_TURN : e_ang;
    base8  = ACC_W'(start_sum) <<< 3;
  end

  // Setup: offset start, angle span, revolution detect.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_start  <= 17'sd0;
      revolution_flag <= 1'b0;
    end else if (state == ST_PREP) begin
      previous_start <= s_ang;
      if (s_ang < previous_start) begin
        revolution_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      start_sum <= 18'(s_ang) + 18'(offset_deg64);
      span      <= 18'(e_wrap) - 18'(s_ang);
    end
  end

  // Interpolation accumulator, already carrying the inversion.
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      acc  <= invert_angle ? -base8 : base8;
      step <= invert_angle ? -ACC_W'(span) : ACC_W'(span);
    end else if (state == ST_OUT && out_free) begin
      acc <= acc + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samp_idx <= '0;
    end else if (state == ST_INIT) begin
      samp_idx <= '0;
    end else if (state == ST_OUT && out_free) begin
      samp_idx <= samp_idx + lpd_pkg::SAMP_AW'(1);
    end
  end

  // Ring slot index with effective length limits.
  always_comb begin
    if (ring_length == 11'd0) begin
      ring_len_eff = CMP_W'(1);
    end else if (CMP_W'(ring_length) > CMP_W'(RING_DEPTH)) begin
      ring_len_eff = CMP_W'(RING_DEPTH);
    end else begin
      ring_len_eff = CMP_W'(ring_length);
    end
    index_inc = CMP_W'(write_index) + CMP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
    end else if (state == ST_OUT && out_free) begin
      write_index <= (index_inc >= ring_len_eff) ? '0 : IDX_W'(index_inc);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      angle_rad_q16   <= q16;
      distance_raw    <= rd_data[23:8];
      intensity_raw   <= rd_data[7:0];
      ring_slot       <= 10'(write_index);
      rpm_q6          <= speed_word;
      revolution_seen <= revolution_flag;
      last_of_packet  <= (samp_idx == lpd_pkg::SAMP_LAST);
    end
  end

endmodule

// ===== tb/sv/lpd_sample_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lpd_sample_checker: sample predictor and comparator for the deframer
// Watches the byte, sample and configuration channels of the lidar packet
// deframer. It keeps its own copy of the framing state and the registers,
// predicts the eight samples of every completed packet, and compares each
// accepted sample field by field against the oldest prediction.
// ============================================================================
module lpd_sample_checker #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [21:0] angle_rad_q16,
  input  logic [15:0]        distance_raw,
  input  logic [7:0]         intensity_raw,
  input  logic [9:0]         ring_slot,
  input  logic [15:0]        rpm_q6,
  input  logic               revolution_seen,
  input  logic               last_of_packet,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatch_count,
  output int                 samples_pending
);

  // Header bytes packed so that byte n sits at bits [8n+7:8n].
  localparam logic [31:0] HDR_WORD = {lpd_pkg::HDR_BYTE3, lpd_pkg::HDR_BYTE2,
                                      lpd_pkg::HDR_BYTE1, lpd_pkg::HDR_BYTE0};
  localparam longint Q16_MAX = (longint'(1) << (lpd_pkg::Q16_W - 1)) - 1;

  typedef struct {
    logic signed [21:0] angle;
    logic [15:0]        distance;
    logic [7:0]         intens;
    logic [9:0]         slot;
    logic [15:0]        rpm;
    logic               rev;
    logic               last;
  } sample_t;

  sample_t expected_samples[$];

  // Register copy.
  logic signed [15:0] offset_deg64;
  logic               invert_on;
  logic [10:0]        ring_len;

  // Framing and packet state.
  logic [1:0]  hdr_pos;
  logic        in_body;
  logic [4:0]  body_pos;
  logic [15:0] speed_w;
  logic [15:0] start_w;
  logic [15:0] end_w;
  logic [15:0] dist_w [lpd_pkg::NUM_SAMPLES];
  logic [7:0]  intens_b [lpd_pkg::NUM_SAMPLES];
  int          prev_start;
  int          slot_idx;
  logic        rev_flag;

  // Converts an angle in 1/512 degree to Q16 radians, rounding half away
  // from zero and saturating to the result width.
  function automatic logic signed [21:0] deg512_to_rad_q16(input longint a);
    longint unsigned mag;
    longint unsigned q;
    longint          r;
    mag = (a < 0) ? longint'(-a) : a;
    q = (mag * lpd_pkg::RAD_FACTOR + (longint'(1) << (lpd_pkg::RAD_SHIFT - 1)))
        >> lpd_pkg::RAD_SHIFT;
    if (q > Q16_MAX + 1) q = Q16_MAX + 1;
    r = (a < 0) ? -longint'(q) : longint'(q);
    if (r > Q16_MAX) r = Q16_MAX;
    return r[21:0];
  endfunction

  // Builds the eight samples of the packet just completed.
  task automatic predict_packet_samples();
    int      s_ang;
    int      e_ang;
    longint  s_off;
    longint  e_off;
    longint  a;
    int      len;
    sample_t smp;
    s_ang = int'(start_w) - int'(lpd_pkg::ANGLE_BIAS);
    e_ang = int'(end_w) - int'(lpd_pkg::ANGLE_BIAS);
    if (e_ang < s_ang) e_ang = e_ang + int'(lpd_pkg::FULL_TURN);
    if (s_ang < prev_start) rev_flag = 1'b1;
    prev_start = s_ang;
    s_off = longint'(s_ang) + longint'(offset_deg64);
    e_off = longint'(e_ang) + longint'(offset_deg64);
    len = int'(ring_len);
    if (len == 0) len = 1;
    if (len > int'(RING_DEPTH)) len = int'(RING_DEPTH);
    for (int i = 0; i < lpd_pkg::NUM_SAMPLES; i++) begin
      a = 8 * s_off + (e_off - s_off) * i;
      if (invert_on) a = -a;
      smp.angle    = deg512_to_rad_q16(a);
      smp.distance = dist_w[i];
      smp.intens   = intens_b[i];
      smp.slot     = slot_idx[9:0];
      smp.rpm      = speed_w;
      smp.rev      = rev_flag;
      smp.last     = (i == lpd_pkg::NUM_SAMPLES - 1);
      expected_samples.push_back(smp);
      slot_idx = slot_idx + 1;
      if (slot_idx >= len) slot_idx = 0;
    end
  endtask

  // Advances the framing state by one received byte.
  task automatic predict_byte(input logic [7:0] b);
    int off;
    int j;
    if (!in_body) begin
      // A mismatching byte drops the hunt back to the first header byte.
      if (b == HDR_WORD[hdr_pos*8 +: 8]) begin
        if (hdr_pos == lpd_pkg::HDR_LAST) begin
          hdr_pos  = '0;
          in_body  = 1'b1;
          body_pos = '0;
        end else begin
          hdr_pos = hdr_pos + 2'd1;
        end
      end else begin
        hdr_pos = '0;
      end
    end else begin
      if (body_pos == lpd_pkg::BODY_SPEED_LO) speed_w[7:0] = b;
      else if (body_pos == lpd_pkg::BODY_SPEED_HI) speed_w[15:8] = b;
      else if (body_pos == lpd_pkg::BODY_START_LO) start_w[7:0] = b;
      else if (body_pos == lpd_pkg::BODY_START_HI) start_w[15:8] = b;
      else if (body_pos >= lpd_pkg::BODY_SAMP_LO &&
               body_pos <= lpd_pkg::BODY_SAMP_HI) begin
        off = int'(body_pos - lpd_pkg::BODY_SAMP_LO);
        j   = off / 3;
        case (2'(off % 3))
          lpd_pkg::TRIP_DIST_LO: dist_w[j][7:0] = b;
          lpd_pkg::TRIP_DIST_HI: dist_w[j][15:8] = b;
          default:               intens_b[j] = b;
        endcase
      end
      else if (body_pos == lpd_pkg::BODY_END_LO) end_w[7:0] = b;
      else if (body_pos == lpd_pkg::BODY_END_HI) end_w[15:8] = b;
      // The two CRC bytes are consumed without any check.
      if (body_pos == lpd_pkg::BODY_LAST) begin
        in_body  = 1'b0;
        body_pos = '0;
        predict_packet_samples();
      end else begin
        body_pos = body_pos + 5'd1;
      end
    end
  endtask

  function automatic int field_mismatch(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compares one sample transaction with the oldest prediction.
  task automatic compare_sample();
    sample_t want;
    if (expected_samples.size() == 0) begin
      $error("sample with no prediction waiting: ring_slot %0d, distance_raw %0d",
             ring_slot, distance_raw);
      mismatch_count = mismatch_count + 1;
    end else begin
      want = expected_samples.pop_front();
      mismatch_count = mismatch_count
        + field_mismatch("angle_rad_q16", want.angle, angle_rad_q16)
        + field_mismatch("distance_raw", want.distance, distance_raw)
        + field_mismatch("intensity_raw", want.intens, intensity_raw)
        + field_mismatch("ring_slot", want.slot, ring_slot)
        + field_mismatch("rpm_q6", want.rpm, rpm_q6)
        + field_mismatch("revolution_seen", want.rev, revolution_seen)
        + field_mismatch("last_of_packet", want.last, last_of_packet);
    end
  endtask

  // Channel monitor: samples are checked before the byte of the same edge
  // is predicted, and the pending count is published for the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      expected_samples.delete();
      mismatch_count = 0;
      offset_deg64   = '0;
      invert_on      = 1'b0;
      ring_len       = 11'd1024;
      hdr_pos        = '0;
      in_body        = 1'b0;
      body_pos       = '0;
      speed_w        = '0;
      start_w        = '0;
      end_w          = '0;
      prev_start     = 0;
      slot_idx       = 0;
      rev_flag       = 1'b0;
      for (int i = 0; i < lpd_pkg::NUM_SAMPLES; i++) begin
        dist_w[i]   = '0;
        intens_b[i] = '0;
      end
      samples_pending <= 0;
    end else begin
      if (out_valid && out_ready) compare_sample();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpd_pkg::CFG_OFFSET:       offset_deg64 = cfg_data;
          lpd_pkg::CFG_INVERT_ANGLE: invert_on = cfg_data[0];
          lpd_pkg::CFG_RING_LENGTH:  ring_len = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_byte(rx_byte);
      samples_pending <= expected_samples.size();
    end
  end

endmodule

// ===== tb/sv/tb_lidar_packet_deframer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_lidar_packet_deframer: testbench top for the lidar packet deframer
// Feeds header hunts, whole packets, broken headers and noise bytes, changes
// the registers between phases, and throttles both channels at random. A
// separate checker predicts and compares every sample.
// ============================================================================
module tb_lidar_packet_deframer;

  localparam int unsigned RING_DEPTH = 1024;
  // Register index past the end of the register list; writes are ignored.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int          TOTAL_BYTES    = 270;
  localparam int          DRAIN_CYCLES   = 32;
  localparam logic [15:0] BIAS_W         = 16'(lpd_pkg::ANGLE_BIAS);
  localparam int          TURN           = int'(lpd_pkg::FULL_TURN);

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic signed [21:0] angle_rad_q16;
  logic [15:0]        distance_raw;
  logic [7:0]         intensity_raw;
  logic [9:0]         ring_slot;
  logic [15:0]        rpm_q6;
  logic               revolution_seen;
  logic               last_of_packet;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  int   mismatch_count;
  int   samples_pending;
  int   sent_bytes;
  bit   quiet;
  logic [15:0] pkt_dist [lpd_pkg::NUM_SAMPLES];
  logic [7:0]  pkt_intens [lpd_pkg::NUM_SAMPLES];

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  lidar_packet_deframer #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angle_rad_q16(angle_rad_q16),
    .distance_raw(distance_raw),
    .intensity_raw(intensity_raw),
    .ring_slot(ring_slot),
    .rpm_q6(rpm_q6),
    .revolution_seen(revolution_seen),
    .last_of_packet(last_of_packet),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lpd_sample_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angle_rad_q16(angle_rad_q16),
    .distance_raw(distance_raw),
    .intensity_raw(intensity_raw),
    .ring_slot(ring_slot),
    .rpm_q6(rpm_q6),
    .revolution_seen(revolution_seen),
    .last_of_packet(last_of_packet),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .samples_pending(samples_pending)
  );

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Sends one byte transaction after an optional gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes = sent_bytes + 1;
  endtask

  task automatic send_header();
    send_byte(lpd_pkg::HDR_BYTE0);
    send_byte(lpd_pkg::HDR_BYTE1);
    send_byte(lpd_pkg::HDR_BYTE2);
    send_byte(lpd_pkg::HDR_BYTE3);
  endtask

  // Sends a full packet from the sample arrays and the given words.
  task automatic send_packet(input logic [15:0] speed, input logic [15:0] start_a,
                             input logic [15:0] end_a, input logic [15:0] crc);
    send_header();
    send_byte(speed[7:0]);
    send_byte(speed[15:8]);
    send_byte(start_a[7:0]);
    send_byte(start_a[15:8]);
    for (int i = 0; i < lpd_pkg::NUM_SAMPLES; i++) begin
      send_byte(pkt_dist[i][7:0]);
      send_byte(pkt_dist[i][15:8]);
      send_byte(pkt_intens[i]);
    end
    send_byte(end_a[7:0]);
    send_byte(end_a[15:8]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic fill_samples(input logic [15:0] d, input logic [7:0] it);
    for (int i = 0; i < lpd_pkg::NUM_SAMPLES; i++) begin
      pkt_dist[i]   = d;
      pkt_intens[i] = it;
    end
  endtask

  // Random packet: mostly angles in the sensor's range, some raw words.
  task automatic send_random_packet();
    int          start_off;
    int          end_off;
    logic [15:0] st;
    logic [15:0] en;
    for (int i = 0; i < lpd_pkg::NUM_SAMPLES; i++) begin
      pkt_dist[i]   = 16'($urandom);
      pkt_intens[i] = 8'($urandom);
    end
    if ($urandom_range(0, 9) < 7) begin
      start_off = $urandom_range(0, TURN - 1);
      end_off   = (start_off + $urandom_range(0, 1500)) % TURN;
      st = BIAS_W + 16'(start_off);
      en = BIAS_W + 16'(end_off);
    end else begin
      st = 16'($urandom);
      en = 16'($urandom);
    end
    send_packet(16'($urandom), st, en, 16'($urandom));
  endtask

  // Partial header broken by a wrong byte, or a doubled first header byte.
  task automatic send_broken_header();
    int          n;
    logic [7:0]  b;
    logic [31:0] hdr;
    hdr = {lpd_pkg::HDR_BYTE3, lpd_pkg::HDR_BYTE2, lpd_pkg::HDR_BYTE1,
           lpd_pkg::HDR_BYTE0};
    if ($urandom_range(0, 3) == 0) begin
      send_byte(lpd_pkg::HDR_BYTE0);
      send_header();
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_byte(hdr[i*8 +: 8]);
      b = 8'($urandom);
      if (b == hdr[n*8 +: 8]) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  // Writes one register transaction, then deasserts cfg_valid.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted sample has come out, then a short tail.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_random_config();
    logic [15:0] offs;
    logic [10:0] len;
    case ($urandom_range(0, 3))
      0:       offs = 16'(-TURN);
      1:       offs = 16'(TURN);
      2:       offs = 16'($urandom_range(0, 2 * TURN) - TURN);
      default: offs = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       len = 11'd1;
      1:       len = 11'd1024;
      2:       len = 11'($urandom_range(1, 16));
      3:       len = 11'($urandom_range(1, 1024));
      default: len = 11'($urandom);
    endcase
    write_reg(lpd_pkg::CFG_OFFSET, offs);
    write_reg(lpd_pkg::CFG_INVERT_ANGLE, 16'($urandom));
    write_reg(lpd_pkg::CFG_RING_LENGTH, {5'($urandom), len});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));
  endtask

  // Receiver: ready in bursts, broken by random stalls.
  initial begin
    int hold;
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = $urandom_range(1, 24);
      out_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int pick;
    int n;
    quiet      = 1'b0;
    sent_bytes = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= lpd_pkg::CFG_OFFSET;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Header mismatches: the wrong byte is not taken as a new first byte.
    send_byte(lpd_pkg::HDR_BYTE0);
    send_byte(lpd_pkg::HDR_BYTE1);
    send_byte(lpd_pkg::HDR_BYTE0);
    send_byte(lpd_pkg::HDR_BYTE0);
    send_byte(lpd_pkg::HDR_BYTE1);
    send_byte(lpd_pkg::HDR_BYTE2);
    send_byte(8'h07);
    send_byte(lpd_pkg::HDR_BYTE0);
    send_header();

    // All-zero and all-one packets at reset settings.
    fill_samples(16'h0000, 8'h00);
    send_packet(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    fill_samples(16'hFFFF, 8'hFF);
    send_packet(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // End angle below start wraps by a full turn; start below the previous
    // one raises the revolution flag.
    for (int i = 0; i < lpd_pkg::NUM_SAMPLES; i++) begin
      pkt_dist[i]   = 16'(i * 16'h1111);
      pkt_intens[i] = 8'(1 << i);
    end
    send_packet(16'h4B00, BIAS_W + 16'd20000, BIAS_W + 16'd500, 16'h1234);

    // Largest positive offset, inverted angles, zero ring length.
    settle();
    write_reg(lpd_pkg::CFG_OFFSET, 16'(TURN));
    write_reg(lpd_pkg::CFG_INVERT_ANGLE, 16'h0001);
    write_reg(lpd_pkg::CFG_RING_LENGTH, 16'h0000);
    fill_samples(16'hA5A5, 8'h5A);
    send_packet(16'h2A40, BIAS_W + 16'd100, BIAS_W + 16'd1000, 16'h0000);

    // Largest negative offset, ring length above the ring depth.
    settle();
    write_reg(lpd_pkg::CFG_OFFSET, 16'(-TURN));
    write_reg(lpd_pkg::CFG_INVERT_ANGLE, 16'hFFFE);
    write_reg(lpd_pkg::CFG_RING_LENGTH, 16'hFFFF);
    send_packet(16'h8001, BIAS_W + 16'(TURN - 1), BIAS_W, 16'hFFFF);

    // Offset beyond its range, a short ring under the current index and a
    // write to an index past the register list.
    settle();
    write_reg(lpd_pkg::CFG_OFFSET, 16'h7FFF);
    write_reg(lpd_pkg::CFG_INVERT_ANGLE, 16'hFFFF);
    write_reg(lpd_pkg::CFG_RING_LENGTH, 16'hF805);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_random_packet();
    settle();
    write_reg(lpd_pkg::CFG_OFFSET, 16'h8000);
    write_reg(lpd_pkg::CFG_INVERT_ANGLE, 16'h0000);
    write_reg(lpd_pkg::CFG_RING_LENGTH, 16'd1024);
    send_random_packet();

    // Random part until the byte total is reached: mostly whole packets,
    // some noise and broken headers.
    while (sent_bytes < TOTAL_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 75) begin
        send_random_packet();
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 95) begin
        send_broken_header();
      end else begin
        settle();
        write_random_config();
      end
    end

    quiet = 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
src/lpd_pkg.sv
src/lpd_sample_ram.sv
src/lpd_byte_parser.sv
src/lpd_rad_conv.sv
src/lidar_packet_deframer.sv
tb/sv/lpd_sample_checker.sv
tb/sv/tb_lidar_packet_deframer.sv
